### rtl/core/bsh_pkg.sv
// Shared types and constants for the shortest-hop search block.
package bsh_pkg;

   localparam int NODES_DEFAULT = 16;
   localparam int NODE_W        = 4;
   localparam int HOP_W         = 4;
   localparam int REQ_DATA_W    = 8;
   localparam int RSP_DATA_W    = 8;

   localparam logic [HOP_W-1:0] HOP_MAX = 4'd15;

   localparam logic OPC_ADD_EDGE = 1'b0;
   localparam logic OPC_QUERY    = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_RD,
      S_ADD_WR_A,
      S_ADD_WR_B,
      S_Q_START,
      S_Q_CHECK,
      S_Q_SCAN,
      S_RESP
   } state_type;

   // Adjacency store access strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } adj_cmd_type;

   // One search answer
   typedef struct packed {
      logic             reachable;
      logic [HOP_W-1:0] hops;
   } res_type;

endpackage

### rtl/core/bsh_ram.sv
// Generic single-clock RAM, one write and one registered read port, read-first.
module bsh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bsh_adj_store.sv
// Adjacency row store: RAM plus per-row valid bits so reset reads as no edges.
module bsh_adj_store
   import bsh_pkg::*;
#(
   parameter int NODES = NODES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  adj_cmd_type              cmd,
   input  logic [$clog2(NODES)-1:0] wr_addr,
   input  logic [NODES-1:0]         wr_row,
   input  logic [$clog2(NODES)-1:0] rd_addr,
   output logic [NODES-1:0]         rd_row
);

   logic [NODES-1:0] row_valid_ff;
   logic [NODES-1:0] row_valid_in;
   logic             rd_ok_ff;
   logic             rd_ok_in;
   logic [NODES-1:0] ram_rd_data;

   bsh_ram #(
      .WIDTH (NODES),
      .DEPTH (NODES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      row_valid_in = row_valid_ff;
      if (cmd.wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
      // sampled with the old flag, matching the read-first RAM
      rd_ok_in = cmd.rd_en ? row_valid_ff[rd_addr] : rd_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_ok_ff     <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rd_ok_ff     <= rd_ok_in;
      end
   end

   assign rd_row = rd_ok_ff ? ram_rd_data : '0;

endmodule

### rtl/core/bsh_search_ctrl.sv
// Sequencer: edge insertion read-modify-write and level-synchronous search.
module bsh_search_ctrl
   import bsh_pkg::*;
#(
   parameter int NODES = NODES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   output logic                     item_ready,
   input  logic                     opcode,
   input  logic [NODE_W-1:0]        node_a,
   input  logic [NODE_W-1:0]        node_b,
   output logic                     res_valid,
   input  logic                     res_ready,
   output res_type                  res,
   output adj_cmd_type              adj_cmd,
   output logic [$clog2(NODES)-1:0] adj_wr_addr,
   output logic [NODES-1:0]         adj_wr_row,
   output logic [$clog2(NODES)-1:0] adj_rd_addr,
   input  logic [NODES-1:0]         adj_rd_row
);

   localparam int IDX_W = $clog2(NODES);
   localparam int EXT_W = ((IDX_W > NODE_W) ? IDX_W : NODE_W) + 1;

   state_type         state_ff, state_in;
   logic              opcode_ff, opcode_in;
   logic [NODE_W-1:0] node_a_ff, node_a_in;
   logic [NODE_W-1:0] node_b_ff, node_b_in;
   logic [NODES-1:0]  visited_ff, visited_in;
   logic [NODES-1:0]  frontier_ff, frontier_in;
   logic [NODES-1:0]  pending_ff, pending_in;
   logic [NODES-1:0]  next_ff, next_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [HOP_W-1:0]  level_ff, level_in;
   res_type           res_ff, res_in;

   logic [EXT_W-1:0]  a_ext, b_ext;
   logic              both_in_range;
   logic [IDX_W-1:0]  idx_a, idx_b;
   logic [NODES-1:0]  bit_a, bit_b;
   logic [NODES-1:0]  low_onehot;
   logic [IDX_W-1:0]  low_idx;
   logic [NODES-1:0]  fresh;

   always_comb begin
      a_ext         = EXT_W'(node_a_ff);
      b_ext         = EXT_W'(node_b_ff);
      both_in_range = (a_ext < EXT_W'(NODES)) && (b_ext < EXT_W'(NODES));
      idx_a         = a_ext[IDX_W-1:0];
      idx_b         = b_ext[IDX_W-1:0];
      bit_a         = NODES'(1) << idx_a;
      bit_b         = NODES'(1) << idx_b;
      // lowest frontier vertex still to expand
      low_onehot    = pending_ff & (~pending_ff + NODES'(1));
      low_idx       = '0;
      for (int i = 0; i < NODES; i++) begin
         if (low_onehot[i]) begin
            low_idx = low_idx | IDX_W'(i);
         end
      end
      fresh = next_ff & ~visited_ff;
   end

   always_comb begin
      state_in    = state_ff;
      opcode_in   = opcode_ff;
      node_a_in   = node_a_ff;
      node_b_in   = node_b_ff;
      visited_in  = visited_ff;
      frontier_in = frontier_ff;
      pending_in  = pending_ff;
      next_in     = next_ff;
      rd_vld_in   = 1'b0;
      level_in    = level_ff;
      res_in      = res_ff;
      adj_cmd     = '0;
      adj_wr_addr = idx_a;
      adj_wr_row  = adj_rd_row | bit_b;
      adj_rd_addr = idx_a;
      item_ready  = 1'b0;
      res_valid   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               opcode_in = opcode;
               node_a_in = node_a;
               node_b_in = node_b;
               state_in  = (opcode == OPC_QUERY) ? S_Q_START : S_ADD_RD;
            end
         end
         S_ADD_RD: begin
            if (both_in_range) begin
               adj_cmd.rd_en = 1'b1;
               state_in      = S_ADD_WR_A;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ADD_WR_A: begin
            adj_cmd.wr_en = 1'b1;
            adj_cmd.rd_en = 1'b1;
            adj_rd_addr   = idx_b;
            state_in      = S_ADD_WR_B;
         end
         S_ADD_WR_B: begin
            adj_cmd.wr_en = 1'b1;
            adj_wr_addr   = idx_b;
            adj_wr_row    = adj_rd_row | bit_a;
            state_in      = S_IDLE;
         end
         S_Q_START: begin
            level_in = '0;
            if (both_in_range) begin
               visited_in  = bit_a;
               frontier_in = bit_a;
               state_in    = S_Q_CHECK;
            end else begin
               res_in   = '0;
               state_in = S_RESP;
            end
         end
         S_Q_CHECK: begin
            if ((visited_ff & bit_b) != '0) begin
               res_in.reachable = 1'b1;
               res_in.hops      = level_ff;
               state_in         = S_RESP;
            end else if (frontier_ff == '0) begin
               res_in   = '0;
               state_in = S_RESP;
            end else begin
               pending_in = frontier_ff;
               next_in    = '0;
               state_in   = S_Q_SCAN;
            end
         end
         S_Q_SCAN: begin
            next_in = next_ff | (rd_vld_ff ? adj_rd_row : '0);
            if (pending_ff != '0) begin
               adj_cmd.rd_en = 1'b1;
               adj_rd_addr   = low_idx;
               pending_in    = pending_ff & ~low_onehot;
               rd_vld_in     = 1'b1;
            end else if (!rd_vld_ff) begin
               // level complete
               visited_in  = visited_ff | fresh;
               frontier_in = fresh;
               level_in    = (level_ff == HOP_MAX) ? level_ff : level_ff + 1'b1;
               state_in    = S_Q_CHECK;
            end
         end
         S_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff   <= opcode_in;
      node_a_ff   <= node_a_in;
      node_b_ff   <= node_b_in;
      visited_ff  <= visited_in;
      frontier_ff <= frontier_in;
      pending_ff  <= pending_in;
      next_ff     <= next_in;
      level_ff    <= level_in;
      res_ff      <= res_in;
   end

   assign res = res_ff;

endmodule

### rtl/core/bfs_shortest_hops.sv
// Top level: shortest hop count over an undirected adjacency matrix.
//
//  channel | dir | tdata (low bit up)                     | tuser
//  req_    | in  | node_a[3:0], node_b[7:4]               | opcode (0 add edge, 1 query)
//  rsp_    | out | reachable[0], hop_count[4:1], 0[7:5]   | -
//
// Sequence: an add-edge transfer occupies the block through an accept plus a
// read-modify-write of both rows through the single RAM write port. A query
// runs level by level from vertex a; each expanded vertex costs one RAM row
// read, and each level costs a check plus the steps that land the last row
// read and fold it into the visited set.
// Reset: synchronous; row valid bits make every row read as empty right away.
// Stalls: a finished answer sits in the output register while the next item
// is accepted; a second answer waits in the sequencer until that register
// frees.
module bfs_shortest_hops
   import bsh_pkg::*;
#(
   parameter int NODES = NODES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // node_a[3:0], node_b[7:4]
   input  logic                  req_tuser,   // opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // reachable[0], hop_count[4:1], pad
);

   localparam int IDX_W = $clog2(NODES);

   adj_cmd_type      adj_cmd;
   logic [IDX_W-1:0] adj_wr_addr;
   logic [IDX_W-1:0] adj_rd_addr;
   logic [NODES-1:0] adj_wr_row;
   logic [NODES-1:0] adj_rd_row;

   logic             res_valid;
   logic             res_ready;
   res_type          res;

   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_res_ff, rsp_res_in;

   bsh_search_ctrl #(
      .NODES (NODES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (req_tvalid),
      .item_ready  (req_tready),
      .opcode      (req_tuser),
      .node_a      (req_tdata[NODE_W-1:0]),
      .node_b      (req_tdata[2*NODE_W-1:NODE_W]),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .adj_cmd     (adj_cmd),
      .adj_wr_addr (adj_wr_addr),
      .adj_wr_row  (adj_wr_row),
      .adj_rd_addr (adj_rd_addr),
      .adj_rd_row  (adj_rd_row)
   );

   bsh_adj_store #(
      .NODES (NODES)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (adj_cmd),
      .wr_addr (adj_wr_addr),
      .wr_row  (adj_wr_row),
      .rd_addr (adj_rd_addr),
      .rd_row  (adj_rd_row)
   );

   // output register: loads when empty or being drained this cycle
   always_comb begin
      res_ready    = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_res_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_res_ff.hops, rsp_res_ff.reachable});

endmodule

### rtl/core/bsh_checker.sv
// Port-level checks for the shortest-hop block, bound to the top level.
module bsh_checker
   import bsh_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // held answer must not change under backpressure
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // unreachable answers carry a zero count and pad bits stay clear
   a_rsp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] || rsp_tdata[4:1] == 4'd0) && rsp_tdata[7:5] == 3'd0)
      else $error("rsp fields malformed");

   // an accepted item takes the sequencer out of idle, so it is not ready in the cycle after the accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted on consecutive cycles");

   // no answer leaves straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind bfs_shortest_hops bsh_checker u_bsh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/sv/tb_bfs_shortest_hops.sv
// Self-checking testbench for the shortest-hop search block: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_bfs_shortest_hops;
   import bsh_pkg::*;

   localparam int NODES      = NODES_DEFAULT;
   localparam int CYCLE_CAP  = 1_000_000;  // generous watchdog bound for ~2000 items
   localparam int RAND_ITEMS = 2000;
   localparam int TAIL_START = 1750;       // no idling on either side from here on
   localparam int DRAIN_AT   = 1000;       // sender waits for every answer here
   localparam int LONG_HOLD  = 400;        // receiver hold-off, in cycles
   localparam int HOLD_AFTER = 300;        // answers seen before the long hold-off

   // One row of the directed table. has_fixed marks rows whose answer is typed in;
   // the rest go through the predictor.
   typedef struct packed {
      logic             op;
      logic [3:0]       node_a;
      logic [3:0]       node_b;
      logic             has_fixed;
      logic             reach;
      logic [HOP_W-1:0] hops;
   } drill_row_type;

   localparam drill_row_type DRILL [27] = '{
      // empty graph: same vertex answers 1/0, distinct vertices are unreachable
      '{OPC_QUERY,    4'd0,  4'd0,  1'b1, 1'b1, 4'd0},
      '{OPC_QUERY,    4'd0,  4'd15, 1'b1, 1'b0, 4'd0},
      '{OPC_QUERY,    4'd15, 4'd15, 1'b1, 1'b1, 4'd0},
      // self loop on vertex 0: still no neighbor, still 0 hops to itself
      '{OPC_ADD_EDGE, 4'd0,  4'd0,  1'b0, 1'b0, 4'd0},
      '{OPC_QUERY,    4'd0,  4'd0,  1'b1, 1'b1, 4'd0},
      '{OPC_QUERY,    4'd0,  4'd1,  1'b1, 1'b0, 4'd0},
      // chain 0-1-2-...-15, endpoints given in both orders
      '{OPC_ADD_EDGE, 4'd0,  4'd1,  1'b0, 1'b0, 4'd0},
      '{OPC_ADD_EDGE, 4'd2,  4'd1,  1'b0, 1'b0, 4'd0},
      '{OPC_ADD_EDGE, 4'd2,  4'd3,  1'b0, 1'b0, 4'd0},
      '{OPC_ADD_EDGE, 4'd4,  4'd3,  1'b0, 1'b0, 4'd0},
      '{OPC_ADD_EDGE, 4'd4,  4'd5,  1'b0, 1'b0, 4'd0},
      '{OPC_ADD_EDGE, 4'd6,  4'd5,  1'b0, 1'b0, 4'd0},
      '{OPC_ADD_EDGE, 4'd6,  4'd7,  1'b0, 1'b0, 4'd0},
      '{OPC_ADD_EDGE, 4'd8,  4'd7,  1'b0, 1'b0, 4'd0},
      '{OPC_ADD_EDGE, 4'd8,  4'd9,  1'b0, 1'b0, 4'd0},
      '{OPC_ADD_EDGE, 4'd10, 4'd9,  1'b0, 1'b0, 4'd0},
      '{OPC_ADD_EDGE, 4'd10, 4'd11, 1'b0, 1'b0, 4'd0},
      '{OPC_ADD_EDGE, 4'd12, 4'd11, 1'b0, 1'b0, 4'd0},
      '{OPC_ADD_EDGE, 4'd12, 4'd13, 1'b0, 1'b0, 4'd0},
      '{OPC_ADD_EDGE, 4'd14, 4'd13, 1'b0, 1'b0, 4'd0},
      '{OPC_ADD_EDGE, 4'd14, 4'd15, 1'b0, 1'b0, 4'd0},
      // longest possible path, both directions
      '{OPC_QUERY,    4'd0,  4'd15, 1'b1, 1'b1, 4'd15},
      '{OPC_QUERY,    4'd15, 4'd0,  1'b1, 1'b1, 4'd15},
      '{OPC_QUERY,    4'd5,  4'd9,  1'b0, 1'b0, 4'd0},
      '{OPC_QUERY,    4'd8,  4'd0,  1'b0, 1'b0, 4'd0},
      // self loop at the far end must not shorten anything
      '{OPC_ADD_EDGE, 4'd15, 4'd15, 1'b0, 1'b0, 4'd0},
      '{OPC_QUERY,    4'd3,  4'd15, 1'b0, 1'b0, 4'd0}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // node_a[3:0], node_b[7:4]
   logic                  req_tuser;   // opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // reachable[0], hop_count[4:1], pad[7:5]

   // predictor state: our own copy of the adjacency matrix
   logic [NODES-1:0] link_rows [NODES];

   res_type hop_answers_q [$];        // answers owed by the block, oldest first
   int      mismatch_count = 0;
   int      answer_count   = 0;
   int      cycle_count    = 0;
   bit      tail_phase     = 1'b0;

   bfs_shortest_hops dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Level-synchronous search over link_rows: expand the whole frontier each
   // level until the target is seen or nothing new turns up.
   function automatic res_type predict_hops(input logic [3:0] src, input logic [3:0] dst);
      logic [NODES-1:0] seen;
      logic [NODES-1:0] front;
      logic [NODES-1:0] grown;
      int               level;
      res_type          ans;
      ans = '0;
      if (src >= NODES || dst >= NODES) begin
         return ans;
      end
      seen  = '0;
      seen[src] = 1'b1;
      front = seen;
      level = 0;
      while (front != '0 && !seen[dst]) begin
         grown = '0;
         for (int v = 0; v < NODES; v++) begin
            if (front[v]) begin
               grown |= link_rows[v];
            end
         end
         grown &= ~seen;
         seen  |= grown;
         front  = grown;
         level++;
      end
      if (seen[dst]) begin
         ans.reachable = 1'b1;
         ans.hops      = (level > HOP_MAX) ? HOP_MAX : level[HOP_W-1:0];
      end
      return ans;
   endfunction

   // Random idle burst ahead of an item; every third block of 100 items runs
   // with no gaps, and the tail runs flat out.
   function automatic int idle_gap(input int idx);
      if (tail_phase || (idx / 100) % 3 == 2 || $urandom_range(0, 3) != 0) begin
         return 0;
      end
      return $urandom_range(1, 6);
   endfunction

   // Offer one item and hold it until the transfer happens, then update the
   // predictor. With gap 0, tvalid stays high straight from the previous
   // transfer so back-to-back items see no bubble.
   task automatic send_item(input logic op, input logic [3:0] a, input logic [3:0] b,
                            input int gap, input bit has_fixed, input res_type fixed_ans);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {b, a};
      do @(posedge clock); while (!req_tready);
      if (op == OPC_ADD_EDGE) begin
         if (a < NODES && b < NODES) begin
            link_rows[a][b] = 1'b1;
            link_rows[b][a] = 1'b1;
         end
      end else begin
         hop_answers_q.push_back(has_fixed ? fixed_ans : predict_hops(a, b));
      end
   endtask

   // Stimulus: reset, directed table, random traffic, drain.
   initial begin
      drill_row_type row;
      res_type       fixed_ans;
      logic          op;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = OPC_ADD_EDGE;
      req_tdata  = '0;
      for (int i = 0; i < NODES; i++) begin
         link_rows[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DRILL); i++) begin
         row                 = DRILL[i];
         fixed_ans.reachable = row.reach;
         fixed_ans.hops      = row.hops;
         send_item(row.op, row.node_a, row.node_b, idle_gap(i), row.has_fixed, fixed_ans);
      end

      // Mostly queries: edges are added sparsely so the graph stays far from
      // complete and long paths keep showing up for a good while.
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i == TAIL_START) begin
            tail_phase = 1'b1;
         end
         if (i == DRAIN_AT) begin
            // sender goes quiet until the block owes nothing
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (hop_answers_q.size() != 0) @(posedge clock);
         end
         op = ($urandom_range(0, 59) == 0) ? OPC_ADD_EDGE : OPC_QUERY;
         send_item(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   (i == DRAIN_AT) ? 0 : idle_gap(i), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (hop_answers_q.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);   // catch any stray answer
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Receiver: random stall bursts, a stall-free stretch in every fourth window
   // of cycle_count, none in the tail, and one long hold-off so the block backs
   // up and drops req_tready while the sender keeps offering.
   initial begin
      int hold_left;
      bit long_done;
      hold_left  = 0;
      long_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!long_done && answer_count >= HOLD_AFTER) begin
            long_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (!tail_phase && (cycle_count / 400) % 4 != 3 &&
                      $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            hold_left = $urandom_range(0, 5);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Answer checker: every response transfer is matched against the oldest
   // owed answer.
   always @(posedge clock) begin : check_answers
      res_type          want;
      logic             got_reach;
      logic [HOP_W-1:0] got_hops;
      if (!reset && rsp_tvalid && rsp_tready) begin
         answer_count++;
         got_reach = rsp_tdata[0];
         got_hops  = rsp_tdata[HOP_W:1];
         if (hop_answers_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected answer: expected none, actual reachable %0d hops %0d",
                     $time, got_reach, got_hops);
         end else begin
            want = hop_answers_q.pop_front();
            if (got_reach !== want.reachable) begin
               mismatch_count++;
               $display("%0t: reachable mismatch: expected %0d, actual %0d",
                        $time, want.reachable, got_reach);
            end
            if (got_hops !== want.hops) begin
               mismatch_count++;
               $display("%0t: hop_count mismatch: expected %0d, actual %0d",
                        $time, want.hops, got_hops);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_CAP) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule

### files.f
rtl/core/bsh_pkg.sv
rtl/core/bsh_ram.sv
rtl/core/bsh_adj_store.sv
rtl/core/bsh_search_ctrl.sv
rtl/core/bfs_shortest_hops.sv
rtl/core/bsh_checker.sv
tb/sv/tb_bfs_shortest_hops.sv
